// File: rtl/pgdc_pkg.sv
// Package: shared constants, codes, types and the genotype decode function.
`default_nettype none
package pgdc_pkg;

  localparam int unsigned MAX_INDIVIDUALS = 65536;

  localparam int unsigned ALLELE_W = 18;
  localparam int unsigned MISS_W   = 17;

  localparam logic [ALLELE_W-1:0] ALLELE_FIELD_MAX = '1;
  localparam logic [MISS_W-1:0]   MISS_FIELD_MAX   = '1;

  localparam longint unsigned ALLELE_CAP_FULL = 2 * longint'(MAX_INDIVIDUALS);
  localparam longint unsigned MISS_CAP_FULL   = longint'(MAX_INDIVIDUALS);

  localparam logic [ALLELE_W-1:0] ALLELE_CAP =
    (ALLELE_CAP_FULL < longint'(ALLELE_FIELD_MAX)) ? ALLELE_W'(ALLELE_CAP_FULL)
                                                   : ALLELE_FIELD_MAX;
  localparam logic [MISS_W-1:0] MISS_CAP =
    (MISS_CAP_FULL < longint'(MISS_FIELD_MAX)) ? MISS_W'(MISS_CAP_FULL)
                                               : MISS_FIELD_MAX;

  // Genotype codes as stored in the packed byte.
  localparam logic [1:0] CODE_HOM_REF = 2'b00;
  localparam logic [1:0] CODE_MISSING = 2'b01;
  localparam logic [1:0] CODE_HET     = 2'b10;
  localparam logic [1:0] CODE_HOM_ALT = 2'b11;

  // Result kinds.
  localparam logic KIND_GENO   = 1'b0;
  localparam logic KIND_TOTALS = 1'b1;

  typedef struct packed {
    logic       kind;
    logic [1:0] dosage;
    logic       is_missing;
    logic       last;
  } pgdc_step_t;

  function automatic logic [1:0] dose_of_code(input logic [1:0] code);
    logic [1:0] d;
    case (code)
      CODE_HOM_REF: d = 2'd0;
      CODE_MISSING: d = 2'd0;
      CODE_HET:     d = 2'd1;
      CODE_HOM_ALT: d = 2'd2;
      default:      d = 2'd0;
    endcase
    return d;
  endfunction

endpackage
`default_nettype wire

// File: rtl/pgdc_if.sv
// Interfaces: input byte channel and result channel.
`default_nettype none
interface pgdc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] packed_byte;
  logic [3:0] keep_mask;
  logic       variant_end;

  modport source(output valid, packed_byte, keep_mask, variant_end, input ready);
  modport sink(input valid, packed_byte, keep_mask, variant_end, output ready);
endinterface

interface pgdc_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [1:0]  dosage;
  logic        is_missing;
  logic [17:0] allele_total;
  logic [16:0] missing_total;
  logic        last;

  modport source(output valid, kind, dosage, is_missing, allele_total, missing_total,
                 last, input ready);
  modport sink(input valid, kind, dosage, is_missing, allele_total, missing_total,
               last, output ready);
endinterface
`default_nettype wire

// File: rtl/pgdc_sched.sv
// Byte holding register that hands out one result step per cycle while advance is high.
`default_nettype none
module pgdc_sched
  import pgdc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       load,
  input  wire logic [7:0] packed_byte,
  input  wire logic [3:0] keep_mask,
  input  wire logic       variant_end,
  input  wire logic       advance,
  output logic            busy,
  output logic            done,
  output pgdc_step_t      step
);

  logic [7:0] hold_byte;
  logic [3:0] pend;
  logic       hold_end;
  logic [1:0] pick;
  logic [3:0] pend_next;
  logic [1:0] code;

  // Lowest pending individual goes first.
  always_comb begin
    if (pend[0]) begin
      pick = 2'd0;
    end else if (pend[1]) begin
      pick = 2'd1;
    end else if (pend[2]) begin
      pick = 2'd2;
    end else begin
      pick = 2'd3;
    end
  end

  always_comb begin
    pend_next = pend & ~(4'b0001 << pick);
    code      = hold_byte[{pick, 1'b0} +: 2];
    if (pend != 4'd0) begin
      step.kind       = KIND_GENO;
      step.dosage     = dose_of_code(code);
      step.is_missing = (code == CODE_MISSING);
      step.last       = (pend_next == 4'd0) && !hold_end;
    end else begin
      step.kind       = KIND_TOTALS;
      step.dosage     = 2'd0;
      step.is_missing = 1'b0;
      step.last       = 1'b1;
    end
  end

  assign done = busy && advance && step.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pend <= 4'd0;
    end else if (load) begin
      // A beat with nothing kept and no variant end yields no result.
      busy <= (keep_mask != 4'd0) || variant_end;
      pend <= keep_mask;
    end else if (busy && advance) begin
      pend <= pend_next;
      if (step.last) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      hold_byte <= packed_byte;
      hold_end  <= variant_end;
    end
  end

endmodule
`default_nettype wire

// File: rtl/pgdc_accum.sv
// Saturating allele and missing accumulators for the current variant.
`default_nettype none
module pgdc_accum
  import pgdc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              advance,
  input  wire pgdc_step_t        step,
  output logic [ALLELE_W-1:0]    allele_acc,
  output logic [MISS_W-1:0]      miss_acc
);

  logic [ALLELE_W:0]   allele_sum;
  logic [ALLELE_W-1:0] allele_acc_next;
  logic [MISS_W-1:0]   miss_acc_next;

  always_comb begin
    allele_sum      = {1'b0, allele_acc} + {(ALLELE_W - 1)'(0), step.dosage};
    allele_acc_next = allele_acc;
    miss_acc_next   = miss_acc;
    if (step.kind == KIND_TOTALS) begin
      allele_acc_next = '0;
      miss_acc_next   = '0;
    end else if (step.is_missing) begin
      if (miss_acc < MISS_CAP) begin
        miss_acc_next = miss_acc + MISS_W'(1);
      end
    end else if (allele_sum > {1'b0, ALLELE_CAP}) begin
      allele_acc_next = ALLELE_CAP;
    end else begin
      allele_acc_next = allele_sum[ALLELE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      allele_acc <= '0;
      miss_acc   <= '0;
    end else if (advance) begin
      allele_acc <= allele_acc_next;
      miss_acc   <= miss_acc_next;
    end
  end

endmodule
`default_nettype wire

// File: rtl/packed_genotype_decode_count_top.sv
// Path: each byte is held in the scheduler's holding register, and each result in the output register.
// Throughput: one result per cycle while the output is not stalled; a byte yields one result per kept
// individual plus one for the totals on a variant end, all through the single
// result port. The next byte is taken in the cycle its predecessor's last result moves.
// Reset: synchronous, active high; clears the output valid, the scheduler and both accumulators.
`default_nettype none
module packed_genotype_decode_count_top
  import pgdc_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  pgdc_in_if.sink       in_ch,
  pgdc_out_if.source    out_ch
);

  logic                busy;
  logic                done;
  logic                load;
  logic                out_load;
  logic                advance;
  pgdc_step_t          step;
  logic [ALLELE_W-1:0] allele_acc;
  logic [MISS_W-1:0]   miss_acc;

  assign out_load    = !out_ch.valid || out_ch.ready;
  assign advance     = busy && out_load;
  assign in_ch.ready = !busy || done;
  assign load        = in_ch.valid && in_ch.ready;

  pgdc_sched u_sched (
    .clk         (clk),
    .rst         (rst),
    .load        (load),
    .packed_byte (in_ch.packed_byte),
    .keep_mask   (in_ch.keep_mask),
    .variant_end (in_ch.variant_end),
    .advance     (advance),
    .busy        (busy),
    .done        (done),
    .step        (step)
  );

  pgdc_accum u_accum (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .step       (step),
    .allele_acc (allele_acc),
    .miss_acc   (miss_acc)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (out_load) begin
      out_ch.valid <= busy;
    end
  end

  // Totals carry the accumulators before this step clears them.
  always_ff @(posedge clk) begin
    if (advance) begin
      out_ch.kind       <= step.kind;
      out_ch.dosage     <= step.dosage;
      out_ch.is_missing <= step.is_missing;
      out_ch.last       <= step.last;
      if (step.kind == KIND_TOTALS) begin
        out_ch.allele_total  <= allele_acc;
        out_ch.missing_total <= miss_acc;
      end else begin
        out_ch.allele_total  <= '0;
        out_ch.missing_total <= '0;
      end
    end
  end

`ifndef SYNTHESIS
  a_geno_no_totals: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && (out_ch.kind == KIND_GENO) |->
      (out_ch.allele_total == '0) && (out_ch.missing_total == '0))
    else $error("decoded result carries nonzero totals");

  a_totals_last: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && (out_ch.kind == KIND_TOTALS) |->
      out_ch.last && (out_ch.dosage == 2'd0) && !out_ch.is_missing)
    else $error("totals result malformed");

  a_missing_dose: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.is_missing |-> (out_ch.dosage == 2'd0))
    else $error("missing genotype with nonzero dosage");

  a_acc_capped: assert property (@(posedge clk) disable iff (rst)
    (allele_acc <= ALLELE_CAP) && (miss_acc <= MISS_CAP))
    else $error("accumulator beyond its cap");

  a_ready_busy: assert property (@(posedge clk) disable iff (rst)
    !in_ch.ready |-> busy && !done)
    else $error("input stalled while no byte is pending");
`endif

endmodule
`default_nettype wire

// File: dv/testbench.sv
// Self-checking testbench for the packed genotype decoder and its variant totals.
`timescale 1ns / 100ps
module testbench;
  import pgdc_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_SLACK    = 10;
  localparam int MAX_PRINTED    = 40;
  localparam int STALL_CYCLES   = 300;

  typedef struct packed {
    logic                kind;
    logic [1:0]          dosage;
    logic                is_missing;
    logic [ALLELE_W-1:0] allele_total;
    logic [MISS_W-1:0]   missing_total;
    logic                last;
  } geno_result_t;

  logic clk = 1'b0;
  logic rst;

  pgdc_in_if  in_ch();
  pgdc_out_if out_ch();

  packed_genotype_decode_count_top DUT (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #5 clk = ~clk;

  // Predictor state: the two running totals of the open variant.
  logic [ALLELE_W-1:0] allele_sum;
  logic [MISS_W-1:0]   missing_count;
  geno_result_t        decoded_queue[$];

  int error_count     = 0;
  int beats_sent      = 0;
  int results_checked = 0;
  int send_gap_max    = 16;
  int recv_gap_max    = 16;
  int hold_request    = 0;
  int idle_cycles     = 0;

  function automatic void decode_and_tally(input logic [7:0] b, input logic [3:0] keep,
                                           input logic vend);
    geno_result_t        r;
    geno_result_t        batch[$];
    logic [1:0]          code;
    logic [ALLELE_W:0]   sum_wide;
    for (int k = 0; k < 4; k++) begin
      code = b[2*k +: 2];
      if (keep[k]) begin
        r = '0;
        r.kind = KIND_GENO;
        if (code == CODE_MISSING) begin
          r.is_missing = 1'b1;
          if (missing_count < MISS_CAP) missing_count = missing_count + MISS_W'(1);
        end else begin
          r.dosage = (code == CODE_HOM_ALT) ? 2'd2 : (code == CODE_HET) ? 2'd1 : 2'd0;
          sum_wide = {1'b0, allele_sum} + (ALLELE_W + 1)'(r.dosage);
          allele_sum = (sum_wide > {1'b0, ALLELE_CAP}) ? ALLELE_CAP
                                                       : sum_wide[ALLELE_W-1:0];
        end
        batch = {batch, r};
      end
    end
    if (vend) begin
      r = '0;
      r.kind = KIND_TOTALS;
      r.allele_total = allele_sum;
      r.missing_total = missing_count;
      batch = {batch, r};
      allele_sum = '0;
      missing_count = '0;
    end
    if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
    foreach (batch[i]) decoded_queue = {decoded_queue, batch[i]};
  endfunction

  task automatic report_mismatch(input string msg);
    // Past a few dozen lines a broken block only repeats itself; keep counting.
    if (error_count < MAX_PRINTED) $display("MISMATCH at %0t: %s", $time, msg);
    error_count++;
  endtask

  task automatic compare_field(input string name, input longint got, input longint want);
    if (got != want)
      report_mismatch($sformatf("result %0d field %s: got %0d, expected %0d",
                                results_checked, name, got, want));
  endtask

  // Offers one byte beat after a random gap and predicts its results on acceptance.
  task automatic push_byte(input logic [7:0] b, input logic [3:0] keep, input logic vend);
    int gap;
    gap = $urandom_range(0, send_gap_max);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.packed_byte <= b;
    in_ch.keep_mask   <= keep;
    in_ch.variant_end <= vend;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    decode_and_tally(b, keep, vend);
    beats_sent++;
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (decoded_queue.size() != 0);
  endtask

  task automatic check_result();
    geno_result_t want;
    results_checked++;
    if (decoded_queue.size() == 0) begin
      report_mismatch($sformatf("result %0d arrived with nothing expected", results_checked));
    end else begin
      want = decoded_queue.pop_front();
      compare_field("kind", out_ch.kind, want.kind);
      compare_field("dosage", out_ch.dosage, want.dosage);
      compare_field("is_missing", out_ch.is_missing, want.is_missing);
      compare_field("allele_total", out_ch.allele_total, want.allele_total);
      compare_field("missing_total", out_ch.missing_total, want.missing_total);
      compare_field("last", out_ch.last, want.last);
    end
  endtask

  // Result side: a random hold-off before each beat, or a long one on request.
  initial begin : result_monitor
    int w;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (rst !== 1'b0);
    forever begin
      if (hold_request > 0) begin
        w = hold_request;
        hold_request = 0;
      end else begin
        w = $urandom_range(0, recv_gap_max);
      end
      if (w > 0) begin
        out_ch.ready <= 1'b0;
        repeat (w) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
      check_result();
    end
  end

  always @(posedge clk) begin
    if (rst === 1'b1 || (in_ch.valid && in_ch.ready) === 1'b1 ||
        (out_ch.valid && out_ch.ready) === 1'b1) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog: no beat moved for %0d cycles", WATCHDOG_LIMIT);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // Each code alone across all four individuals, closing the variant on the last.
  task automatic test_each_code();
    push_byte(8'h00, 4'hF, 1'b0);
    push_byte(8'h55, 4'hF, 1'b0);
    push_byte(8'hAA, 4'hF, 1'b0);
    push_byte(8'hFF, 4'hF, 1'b1);
  endtask

  // Byte 0xE4 carries codes 0,1,2,3 in order, so every keep pattern shows its own subset.
  task automatic test_keep_masks();
    for (int k = 0; k < 16; k++) push_byte(8'hE4, 4'(k), 1'(k % 4 == 3));
    // Nothing kept and the variant closes: a lone totals beat.
    push_byte(8'h1B, 4'h0, 1'b1);
  endtask

  // The receiver stalls for a long stretch while bytes keep coming at full rate.
  task automatic test_output_stall();
    send_gap_max = 0;
    hold_request = STALL_CYCLES;
    for (int i = 0; i < 30; i++) push_byte(8'($urandom), 4'hF, 1'(i % 5 == 4));
    send_gap_max = 16;
  endtask

  task automatic test_drain_pause();
    for (int v = 0; v < 3; v++) begin
      for (int i = 0; i < 3; i++) push_byte(8'($urandom), 4'hF, 1'(i == 2));
      wait_drained();
    end
  endtask

  // Well-formed variants with random genotypes, padded tails and some filtered
  // individuals, salted with early variant ends.
  task automatic test_random_variants(input int target);
    int         produced;
    int         nbytes;
    logic [7:0] b;
    logic [3:0] keep;
    logic       vend;
    produced = 0;
    while (produced < target) begin
      if ($urandom_range(0, 5) == 0) begin
        send_gap_max = 0;
        recv_gap_max = 0;
      end else begin
        send_gap_max = 16;
        recv_gap_max = 16;
      end
      nbytes = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 30) : $urandom_range(1, 12);
      for (int i = 0; i < nbytes; i++) begin
        b = 8'($urandom);
        keep = 4'hF;
        vend = (i == nbytes - 1);
        if (vend && $urandom_range(0, 2) == 0) keep = 4'($urandom_range(0, 2) * 2 + 1) | 4'h1;
        if (vend && keep != 4'hF) keep = (keep == 4'h3) ? 4'h3 : (keep == 4'h5 ? 4'h7 : 4'h1);
        if ($urandom_range(0, 9) == 0) keep = 4'($urandom_range(0, 15));
        if (!vend && $urandom_range(0, 19) == 0) vend = 1'b1;
        push_byte(b, keep, vend);
        if (keep != 4'h0 || vend) produced++;
      end
    end
    send_gap_max = 16;
    recv_gap_max = 16;
  endtask

  initial begin
    allele_sum = '0;
    missing_count = '0;
    rst               <= 1'b1;
    in_ch.valid       <= 1'b0;
    in_ch.packed_byte <= '0;
    in_ch.keep_mask   <= '0;
    in_ch.variant_end <= 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_each_code();
    test_keep_masks();
    test_output_stall();
    test_drain_pause();
    test_random_variants(250);

    wait_drained();
    repeat (DRAIN_SLACK) @(posedge clk);
    $display("Run covered %0d byte beats and %0d result beats: each code, all keep masks,",
             beats_sent, results_checked);
    $display("a long output stall, drained pauses and random variants with padded tails.");
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/pgdc_pkg.sv
rtl/pgdc_if.sv
rtl/pgdc_sched.sv
rtl/pgdc_accum.sv
rtl/packed_genotype_decode_count_top.sv
dv/testbench.sv
